>>> design/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg: shared types, constants and helpers for quaternion vector rotation
// Word formats of both channels, coefficient bundle, rounding and clamping.
// ----------------------------------------------------------------------------
package qvr_pkg;

	localparam int DataW   = 32;
	localparam int CfgIdxW = 3;

	// register indexes of the configuration port
	typedef enum logic [CfgIdxW-1:0] {
		REG_QUAT_W   = 3'd0,
		REG_QUAT_X   = 3'd1,
		REG_QUAT_Y   = 3'd2,
		REG_QUAT_Z   = 3'd3,
		REG_ROW_MODE = 3'd4
	} reg_idx_t;

	// wide signed working type for rounding and clamping
	typedef logic signed [69:0] wide_t;

	localparam wide_t ONE_Q30 = wide_t'(1) <<< 30;
	localparam wide_t LIM_T   = (wide_t'(1) <<< 32) - wide_t'(1);
	localparam wide_t LIM_K   = (wide_t'(1) <<< 33) - wide_t'(1);

	typedef struct packed {
		logic signed [DataW-1:0] vec_x;
		logic signed [DataW-1:0] vec_y;
		logic signed [DataW-1:0] vec_z;
	} in_word_t;

	typedef struct packed {
		logic signed [DataW-1:0] out_x;
		logic signed [DataW-1:0] out_y;
		logic signed [DataW-1:0] out_z;
		logic                    applied;
		logic                    saturated;
	} out_word_t;

	// coefficients derived from the quaternion; new words are accepted only while they are not being recomputed
	typedef struct packed {
		logic               applied;
		logic               row_mode;
		logic signed [31:0] c2;
		logic signed [32:0] s2;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
	} coef_t;

	// floor(x / 2^n + 1/2)
	function automatic wide_t rnd_shift(input wide_t x, input int unsigned n);
		wide_t y;
		y = x + (wide_t'(1) <<< (n - 1));
		return y >>> n;
	endfunction

	// symmetric clamp to +-lim
	function automatic wide_t clamp(input wide_t x, input wide_t lim);
		wide_t r;
		r = x;
		if (x > lim) r = lim;
		if (x < -lim) r = -lim;
		return r;
	endfunction

endpackage

>>> design/qvr_coef.sv
// ----------------------------------------------------------------------------
// qvr_coef: configuration registers and coefficient sequencer
// Normalises the quaternion, takes two integer square roots bit by bit, runs
// five restoring divisions on one shared divider and forms c2 and s2.
// ----------------------------------------------------------------------------
module qvr_coef (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_en,
	input  logic [qvr_pkg::CfgIdxW-1:0]   cfg_addr,
	input  logic [qvr_pkg::DataW-1:0]     cfg_data,
	output qvr_pkg::coef_t                coef,
	output logic                          busy
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_NORM = 7'b0000010,
		ST_SQ   = 7'b0000100,
		ST_SQRT = 7'b0001000,
		ST_DIV  = 7'b0010000,
		ST_MUL  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t                state_q;
	logic signed [31:0]    quat_q [4];
	logic                  row_mode_q;
	logic [29:0]           nq_q [4];
	logic                  neg_q [4];
	logic                  zero_q;
	logic [4:0]            cnt_q;
	logic [2:0]            idx_q;
	logic [62:0]           acc_q;
	logic [62:0]           v2_q;
	logic [63:0]           rn_v_q, rn_r_q, rv_v_q, rv_r_q, b_q;
	logic [31:0]           rem_q;
	logic [29:0]           quo_q;
	logic signed [31:0]    divr_q [5];
	logic signed [63:0]    cc_q, ss_q, cs_q;
	logic signed [31:0]    c2_q;
	logic signed [32:0]    s2_q;
	logic                  applied_q;

	// normalisation
	logic [31:0] mag [4];
	logic [31:0] orm;
	logic [4:0]  top;
	logic [31:0] nsh [4];

	always_comb begin
		orm = '0;
		for (int i = 0; i < 4; i++) begin
			mag[i] = quat_q[i][31] ? 32'(-quat_q[i]) : quat_q[i];
			orm = orm | mag[i];
		end
		top = '0;
		for (int k = 0; k < 32; k++) begin
			if (orm[k]) top = 5'(k);
		end
		for (int i = 0; i < 4; i++) begin
			nsh[i] = (top > 5'd29) ? (mag[i] >> (top - 5'd29)) : (mag[i] << (5'd29 - top));
		end
	end

	// one square per cycle: x, y, z, then w
	logic [1:0]  sq_sel;
	logic [59:0] sq;
	assign sq_sel = cnt_q[1:0] + 2'd1;
	assign sq     = nq_q[sq_sel] * nq_q[sq_sel];

	// square root steps for both sums
	logic [63:0] rn_t, rv_t;
	logic        rn_ge, rv_ge;
	assign rn_t  = rn_r_q + b_q;
	assign rv_t  = rv_r_q + b_q;
	assign rn_ge = rn_v_q >= rn_t;
	assign rv_ge = rv_v_q >= rv_t;

	// shared divider operands
	logic [30:0] m_sel;
	logic [31:0] den_sel;
	logic        neg_sel;
	logic [32:0] trial;
	logic        dge;
	logic [30:0] quo_fin;

	always_comb begin
		case (idx_q)
			3'd0:    begin m_sel = 31'(nq_q[0]); neg_sel = neg_q[0]; end
			3'd1:    begin m_sel = rv_r_q[30:0]; neg_sel = 1'b0;     end
			3'd2:    begin m_sel = 31'(nq_q[1]); neg_sel = neg_q[1]; end
			3'd3:    begin m_sel = 31'(nq_q[2]); neg_sel = neg_q[2]; end
			default: begin m_sel = 31'(nq_q[3]); neg_sel = neg_q[3]; end
		endcase
		den_sel = (idx_q < 3'd2) ? rn_r_q[31:0] : rv_r_q[31:0];
		trial   = {rem_q, (cnt_q == 5'd1) ? m_sel[0] : 1'b0};
		dge     = trial >= {1'b0, den_sel};
		quo_fin = {quo_q, dge};
	end

	// shared multiplier for c*c, s*s, c*s
	logic signed [31:0] op_a, op_b;
	logic signed [63:0] prod;
	assign op_a = (cnt_q[1:0] == 2'd1) ? divr_q[1] : divr_q[0];
	assign op_b = (cnt_q[1:0] == 2'd0) ? divr_q[0] : divr_q[1];
	assign prod = op_a * op_b;

	// final rounding
	qvr_pkg::wide_t c2_w, s2_w;
	always_comb begin
		c2_w = qvr_pkg::rnd_shift(qvr_pkg::wide_t'(cc_q) - qvr_pkg::wide_t'(ss_q), 30);
		s2_w = qvr_pkg::rnd_shift(qvr_pkg::wide_t'(cs_q), 29);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q[0]  <= 32'sd65536;
			quat_q[1]  <= '0;
			quat_q[2]  <= '0;
			quat_q[3]  <= '0;
			row_mode_q <= 1'b0;
		end else if (cfg_en) begin
			unique case (cfg_addr)
				qvr_pkg::REG_QUAT_W:   quat_q[0]  <= cfg_data;
				qvr_pkg::REG_QUAT_X:   quat_q[1]  <= cfg_data;
				qvr_pkg::REG_QUAT_Y:   quat_q[2]  <= cfg_data;
				qvr_pkg::REG_QUAT_Z:   quat_q[3]  <= cfg_data;
				qvr_pkg::REG_ROW_MODE: row_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer: restart after reset and after any quaternion write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_NORM;
			cnt_q     <= '0;
			idx_q     <= '0;
			applied_q <= 1'b0;
		end else if (cfg_en && (cfg_addr < qvr_pkg::REG_ROW_MODE)) begin
			state_q <= ST_NORM;
		end else begin
			unique case (state_q)
				ST_IDLE: ;
				ST_NORM: begin
					cnt_q   <= '0;
					state_q <= (orm == '0) ? ST_FIN : ST_SQ;
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q[1:0] == 2'd3) begin
						cnt_q   <= '0;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						cnt_q   <= '0;
						idx_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd4) begin
							cnt_q   <= '0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q[1:0] == 2'd2) state_q <= ST_FIN;
				end
				ST_FIN: begin
					applied_q <= !zero_q && (divr_q[1] >= 32'sd2);
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers of the sequencer
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_NORM: begin
				zero_q <= (orm == '0);
				acc_q  <= '0;
				for (int i = 0; i < 4; i++) begin
					nq_q[i]  <= nsh[i][29:0];
					neg_q[i] <= quat_q[i][31];
				end
			end
			ST_SQ: begin
				acc_q <= acc_q + 63'(sq);
				if (cnt_q[1:0] == 2'd2) v2_q <= acc_q + 63'(sq);
				if (cnt_q[1:0] == 2'd3) begin
					rn_v_q <= 64'(acc_q) + 64'(sq);
					rv_v_q <= 64'(v2_q);
					rn_r_q <= '0;
					rv_r_q <= '0;
					b_q    <= 64'(1) << 62;
				end
			end
			ST_SQRT: begin
				if (rn_ge) begin
					rn_v_q <= rn_v_q - rn_t;
					rn_r_q <= (rn_r_q >> 1) + b_q;
				end else begin
					rn_r_q <= rn_r_q >> 1;
				end
				if (rv_ge) begin
					rv_v_q <= rv_v_q - rv_t;
					rv_r_q <= (rv_r_q >> 1) + b_q;
				end else begin
					rv_r_q <= rv_r_q >> 1;
				end
				b_q <= b_q >> 2;
			end
			ST_DIV: begin
				if (cnt_q == 5'd0) begin
					rem_q <= 32'(m_sel >> 1);
					quo_q <= '0;
				end else begin
					rem_q <= dge ? 32'(trial - {1'b0, den_sel}) : trial[31:0];
					quo_q <= quo_fin[29:0];
					if (cnt_q == 5'd31) begin
						divr_q[idx_q] <= neg_sel ? -$signed({1'b0, quo_fin})
						                         : $signed({1'b0, quo_fin});
					end
				end
			end
			ST_MUL: begin
				case (cnt_q[1:0])
					2'd0:    cc_q <= prod;
					2'd1:    ss_q <= prod;
					default: cs_q <= prod;
				endcase
			end
			ST_FIN: begin
				c2_q <= c2_w[31:0];
				s2_q <= s2_w[32:0];
			end
			default: ;
		endcase
	end

	assign busy          = (state_q != ST_IDLE);
	assign coef.applied  = applied_q;
	assign coef.row_mode = row_mode_q;
	assign coef.c2       = c2_q;
	assign coef.s2       = s2_q;
	assign coef.ax       = divr_q[2];
	assign coef.ay       = divr_q[3];
	assign coef.az       = divr_q[4];

endmodule

>>> design/qvr_pipe.sv
// ----------------------------------------------------------------------------
// qvr_pipe: six-stage rotation datapath
// Products, rounding, scale terms, axis terms and the saturating sum, with a
// valid bit per stage and a ready chain so a stall drops nothing.
// ----------------------------------------------------------------------------
module qvr_pipe (
	input  logic                clk,
	input  logic                arst_n,
	input  qvr_pkg::coef_t      coef,
	input  logic                busy,
	input  logic                in_valid,
	output logic                in_ready,
	input  qvr_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output qvr_pkg::out_word_t  out_data
);

	logic signed [31:0] a [3];
	logic signed [31:0] e_in [3];
	assign a[0]    = coef.ax;
	assign a[1]    = coef.ay;
	assign a[2]    = coef.az;
	assign e_in[0] = in_data.vec_x;
	assign e_in[1] = in_data.vec_y;
	assign e_in[2] = in_data.vec_z;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;
	logic accept;

	// advance a stage when it is empty or its successor advances
	assign en6      = !v_s6 || out_ready;
	assign en5      = !v_s5 || en6;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1 && !busy;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= accept;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	logic signed [31:0] e_s1 [3], e_s2 [3], e_s3 [3], e_s4 [3], e_s5 [3];
	logic signed [63:0] p_s1 [3][3];
	logic signed [63:0] ce_s1 [3];
	logic signed [33:0] t_s2;
	logic signed [33:0] f_s2 [3];
	logic signed [33:0] cer_s2 [3], cer_s3 [3], cer_s4 [3], cer_s5 [3];
	logic signed [66:0] kp_s3;
	logic signed [66:0] sf_s3 [3];
	logic signed [34:0] tk_s4;
	logic signed [35:0] sfr_s4 [3], sfr_s5 [3];
	logic signed [66:0] ta_s5 [3];

	// stage 1: all axis by vector products and c2 by vector
	always_ff @(posedge clk) begin
		if (en1) begin
			for (int i = 0; i < 3; i++) begin
				e_s1[i]  <= e_in[i];
				ce_s1[i] <= coef.c2 * e_in[i];
				for (int j = 0; j < 3; j++) p_s1[i][j] <= a[i] * e_in[j];
			end
		end
	end

	// stage 2: dot and cross products, rounded and clamped
	qvr_pkg::wide_t dot_w, t_w;
	qvr_pkg::wide_t f_w [3], fr_w [3], cer_w [3];
	always_comb begin
		dot_w = qvr_pkg::wide_t'(p_s1[0][0]) + qvr_pkg::wide_t'(p_s1[1][1])
		      + qvr_pkg::wide_t'(p_s1[2][2]);
		t_w   = qvr_pkg::clamp(qvr_pkg::rnd_shift(dot_w, 30), qvr_pkg::LIM_T);
		f_w[0] = qvr_pkg::wide_t'(p_s1[1][2]) - qvr_pkg::wide_t'(p_s1[2][1]);
		f_w[1] = qvr_pkg::wide_t'(p_s1[2][0]) - qvr_pkg::wide_t'(p_s1[0][2]);
		f_w[2] = qvr_pkg::wide_t'(p_s1[0][1]) - qvr_pkg::wide_t'(p_s1[1][0]);
		for (int i = 0; i < 3; i++) begin
			if (coef.row_mode) f_w[i] = -f_w[i];
			fr_w[i]  = qvr_pkg::clamp(qvr_pkg::rnd_shift(f_w[i], 30), qvr_pkg::LIM_T);
			cer_w[i] = qvr_pkg::rnd_shift(qvr_pkg::wide_t'(ce_s1[i]), 30);
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			t_s2 <= t_w[33:0];
			for (int i = 0; i < 3; i++) begin
				e_s2[i]   <= e_s1[i];
				f_s2[i]   <= fr_w[i][33:0];
				cer_s2[i] <= cer_w[i][33:0];
			end
		end
	end

	// stage 3: (1 - c2) * t and s2 * cross
	qvr_pkg::wide_t omc_w;
	logic signed [32:0] omc;
	always_comb begin
		omc_w = qvr_pkg::ONE_Q30 - qvr_pkg::wide_t'(coef.c2);
		omc   = omc_w[32:0];
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			kp_s3 <= omc * t_s2;
			for (int i = 0; i < 3; i++) begin
				e_s3[i]   <= e_s2[i];
				cer_s3[i] <= cer_s2[i];
				sf_s3[i]  <= coef.s2 * f_s2[i];
			end
		end
	end

	// stage 4: round the scale terms
	qvr_pkg::wide_t tk_w;
	qvr_pkg::wide_t sfr_w [3];
	always_comb begin
		tk_w = qvr_pkg::clamp(qvr_pkg::rnd_shift(qvr_pkg::wide_t'(kp_s3), 30), qvr_pkg::LIM_K);
		for (int i = 0; i < 3; i++) begin
			sfr_w[i] = qvr_pkg::rnd_shift(qvr_pkg::wide_t'(sf_s3[i]), 30);
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			tk_s4 <= tk_w[34:0];
			for (int i = 0; i < 3; i++) begin
				e_s4[i]   <= e_s3[i];
				cer_s4[i] <= cer_s3[i];
				sfr_s4[i] <= sfr_w[i][35:0];
			end
		end
	end

	// stage 5: axis terms
	always_ff @(posedge clk) begin
		if (en5) begin
			for (int i = 0; i < 3; i++) begin
				e_s5[i]   <= e_s4[i];
				cer_s5[i] <= cer_s4[i];
				sfr_s5[i] <= sfr_s4[i];
				ta_s5[i]  <= tk_s4 * a[i];
			end
		end
	end

	// stage 6: sum, saturate, or pass the vector through
	qvr_pkg::wide_t sum_w [3];
	logic signed [31:0] res [3];
	logic [2:0] sat;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_w[i] = qvr_pkg::rnd_shift(qvr_pkg::wide_t'(ta_s5[i]), 30)
			         + qvr_pkg::wide_t'(cer_s5[i]) + qvr_pkg::wide_t'(sfr_s5[i]);
			sat[i]   = 1'b0;
			res[i]   = sum_w[i][31:0];
			if (sum_w[i] > qvr_pkg::wide_t'(32'sh7fffffff)) begin
				res[i] = 32'sh7fffffff;
				sat[i] = 1'b1;
			end
			if (sum_w[i] < qvr_pkg::wide_t'(32'sh80000000)) begin
				res[i] = 32'sh80000000;
				sat[i] = 1'b1;
			end
			if (!coef.applied) begin
				res[i] = e_s5[i];
				sat[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			out_data.out_x     <= res[0];
			out_data.out_y     <= res[1];
			out_data.out_z     <= res[2];
			out_data.applied   <= coef.applied;
			out_data.saturated <= |sat;
		end
	end

	assign out_valid = v_s6;

endmodule

>>> design/quaternion_vector_rotation.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotation: rotate Q16.16 vectors by a configured quaternion
//
//   channel   handshake                 payload
//   in        in_valid / in_ready       in_data  (vec_x, vec_y, vec_z)
//   out       out_valid / out_ready     out_data (out_x..z, applied, saturated)
//   cfg       cfg_en                    cfg_addr, cfg_data
//
// One word per cycle while out_ready is high and the sequencer is idle; each
// word passes through the datapath stages, the last being the output
// register. The quaternion terms come from a sequencer that runs after reset
// and after each quaternion write (normalise, four squares, 32 root steps,
// five divisions, three products, final rounding), or goes from normalise
// to final rounding for the zero quaternion; in_ready is low while it runs.
// Each stage holds its word while the stage after it is full and stalled.
// ----------------------------------------------------------------------------
module quaternion_vector_rotation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_en,
	input  logic [qvr_pkg::CfgIdxW-1:0]   cfg_addr,
	input  logic [qvr_pkg::DataW-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  qvr_pkg::in_word_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output qvr_pkg::out_word_t            out_data
);

	qvr_pkg::coef_t coef;
	logic           busy;

	// derive rotation coefficients from the quaternion
	qvr_coef u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_en   (cfg_en),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.coef     (coef),
		.busy     (busy)
	);

	// rotate each word
	qvr_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef),
		.busy      (busy),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
